// ===== rtl/vat_pkg.sv =====
// Shared types, constants and helper functions for the vertex transform block.
`default_nettype none

package vat_pkg;

  // Transform modes held in the mode register
  typedef enum logic [3:0] {
    MODE_TRANSLATE = 4'd0,
    MODE_SCALE     = 4'd1,
    MODE_SCALE_PT  = 4'd2,
    MODE_ROT_X     = 4'd3,
    MODE_ROT_Y     = 4'd4,
    MODE_ROT_Z     = 4'd5,
    MODE_REFL_XY   = 4'd6,
    MODE_REFL_YZ   = 4'd7,
    MODE_REFL_XZ   = 4'd8
  } mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_SCALE_X  = 3'd1,
    REG_SCALE_Y  = 3'd2,
    REG_SCALE_Z  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6,
    REG_ANGLE    = 3'd7
  } reg_idx_t;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Angle folding and fixed point trig constants
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [31:0] Q28_ONE     = 32'sd268435456;
  localparam logic signed [15:0] Q13_ONE     = 16'sd8192;

  // Last series step of the sine and cosine lists in the divisor table
  localparam logic [3:0] SIN_LAST = 4'd3;
  localparam logic [3:0] COS_LAST = 4'd8;

  // Axonometric view constants, Q16
  localparam logic signed [17:0] PROJ_C  = 18'sd56749;
  localparam logic signed [17:0] PROJ_S  = 18'sd32780;
  localparam logic signed [17:0] PROJ_S2 = 18'sd16396;
  localparam logic signed [17:0] PROJ_CS = 18'sd28385;

  // Trig unit status seen by the transform pipeline
  typedef struct packed {
    logic               busy;
    logic signed [15:0] cos_val;
    logic signed [15:0] sin_val;
  } trig_status_t;

  // Taylor series divisors as reciprocals: floor(n / d) = (n * recip) >> shift,
  // exact for every dividend below 2^30. Sine steps first, then cosine steps
  // (divisors 72, 42, 20, 6, then 90, 56, 30, 12, 2).
  function automatic logic [31:0] series_recip(input logic [3:0] idx);
    case (idx)
      4'd0:    return 32'd1908874354;
      4'd1:    return 32'd1636178018;
      4'd2:    return 32'd1717986919;
      4'd3:    return 32'd1431655766;
      4'd4:    return 32'd1527099484;
      4'd5:    return 32'd1227133514;
      4'd6:    return 32'd1145324613;
      4'd7:    return 32'd1431655766;
      4'd8:    return 32'd1073741824;
      default: return 32'd1073741824;
    endcase
  endfunction

  function automatic logic [5:0] series_shift(input logic [3:0] idx);
    case (idx)
      4'd0:    return 6'd37;
      4'd1:    return 6'd36;
      4'd2:    return 6'd35;
      4'd3:    return 6'd33;
      4'd4:    return 6'd37;
      4'd5:    return 6'd36;
      4'd6:    return 6'd35;
      4'd7:    return 6'd34;
      4'd8:    return 6'd31;
      default: return 6'd31;
    endcase
  endfunction

  // Clamp a wide signed value into 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vat_trig.sv =====
// Sequential sine/cosine unit: Taylor series in Q28 on one shared multiplier.
`default_nettype none

module vat_trig import vat_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic signed [15:0] angle,
  output trig_status_t       status
);

  typedef enum logic [3:0] {
    T_IDLE, T_SQ, T_X2, T_MUL, T_DLOAD, T_DIV, T_QUO, T_SINM, T_SINF, T_COSF
  } tstate_t;

  tstate_t            state;
  logic signed [31:0] x;
  logic signed [31:0] x2;
  logic signed [31:0] acc;
  logic signed [63:0] prod;
  logic [31:0]        mag;
  logic               neg;
  logic [3:0]         kidx;
  logic               flip;
  logic signed [15:0] sin_val;
  logic signed [15:0] cos_val;

  logic signed [16:0] a_fold;
  logic               fold_flip;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [35:0] p_sh;
  logic [35:0]        p_mag;
  logic [5:0]         dsh;
  logic [63:0]        quo_w;
  logic [31:0]        quo;
  logic [31:0]        q_s;
  logic signed [31:0] acc_new;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;

  // Round half up from Q28 to Q13 and clamp to one
  function automatic logic signed [15:0] to_q13(input logic signed [35:0] v);
    logic signed [36:0] t;
    logic signed [21:0] r;
    t = 37'(v) + 37'sd16384;
    r = t[36:15];
    if (r > 22'sd8192) begin
      return 16'sd8192;
    end else if (r < -22'sd8192) begin
      return -16'sd8192;
    end else begin
      return r[15:0];
    end
  endfunction

  always_comb begin
    // Fold the angle into the half turn around zero
    a_fold    = 17'(angle);
    fold_flip = 1'b0;
    if (17'(angle) > HALF_PI_Q13) begin
      a_fold    = PI_Q13 - 17'(angle);
      fold_flip = 1'b1;
    end else if (17'(angle) < -HALF_PI_Q13) begin
      a_fold    = -PI_Q13 - 17'(angle);
      fold_flip = 1'b1;
    end

    // Shared multiplier operands
    case (state)
      T_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      T_MUL: begin
        mul_a = x2;
        mul_b = acc;
      end
      T_DIV: begin
        mul_a = $signed(mag);
        mul_b = $signed(series_recip(kidx));
      end
      default: begin
        mul_a = x;
        mul_b = acc;
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);

    // Floor of the Q28 product and its magnitude for the divide
    p_sh  = prod[63:28];
    p_mag = p_sh[35] ? 36'(-p_sh) : 36'(p_sh);

    // Quotient from the reciprocal product, sign restored (truncates toward zero)
    dsh     = series_shift(kidx);
    quo_w   = $unsigned(prod) >> dsh;
    quo     = quo_w[31:0];
    q_s     = neg ? -quo : quo;
    acc_new = Q28_ONE - $signed(q_s);

    sin_q = to_q13(p_sh);
    cos_q = to_q13(36'(acc));
  end

  // Sequence the series: square, then multiply and divide per term
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_IDLE;
      sin_val <= 16'sd0;
      cos_val <= Q13_ONE;
    end else begin
      case (state)
        T_IDLE: begin
          if (load) begin
            x     <= {a_fold, 15'b0};
            flip  <= fold_flip;
            state <= T_SQ;
          end
        end
        T_SQ: begin
          prod  <= mul_p;
          state <= T_X2;
        end
        T_X2: begin
          x2    <= prod[59:28];
          acc   <= Q28_ONE;
          kidx  <= 4'd0;
          state <= T_MUL;
        end
        T_MUL: begin
          prod  <= mul_p;
          state <= T_DLOAD;
        end
        T_DLOAD: begin
          mag   <= p_mag[31:0];
          neg   <= p_sh[35];
          state <= T_DIV;
        end
        T_DIV: begin
          prod  <= mul_p;
          state <= T_QUO;
        end
        T_QUO: begin
          acc  <= acc_new;
          kidx <= kidx + 4'd1;
          if (kidx == SIN_LAST) begin
            state <= T_SINM;
          end else if (kidx == COS_LAST) begin
            state <= T_COSF;
          end else begin
            state <= T_MUL;
          end
        end
        T_SINM: begin
          prod  <= mul_p;
          state <= T_SINF;
        end
        T_SINF: begin
          sin_val <= sin_q;
          acc     <= Q28_ONE;
          state   <= T_MUL;
        end
        T_COSF: begin
          cos_val <= flip ? -cos_q : cos_q;
          state   <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign status.busy    = (state != T_IDLE);
  assign status.cos_val = cos_val;
  assign status.sin_val = sin_val;

endmodule

`default_nettype wire

// ===== rtl/vertex_affine_transform_project.sv =====
// Top level: configuration registers, six-stage transform and projection pipeline.
//
//   channel   handshake          payload
//   ------    ---------          -------
//   vertex    start / busy       vertex_x, vertex_y, vertex_z
//   result    done (strobe)      out_x, out_y, out_z, proj_x, proj_y
//   config    cfg_en             cfg_index, cfg_data
//
// A vertex is taken on every cycle with start high and busy low; its result
// shows on done after passing the pipeline registers, one result per cycle while
// busy is low. busy is high after a write of the angle register while the
// sequential trig unit (one shared multiplier, each series divide done as a
// reciprocal multiply) derives sine and cosine. Reset is synchronous and
// clears all control state.
// The result side has no back pressure: every done beat is final.
`default_nettype none

module vertex_affine_transform_project import vat_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic signed [COORD_BITS-1:0] vertex_z,
  input  logic                         cfg_en,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  output logic                         done,
  output logic signed [31:0]           out_x,
  output logic signed [31:0]           out_y,
  output logic signed [31:0]           out_z,
  output logic signed [31:0]           proj_x,
  output logic signed [31:0]           proj_y
);

  localparam int UW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
  localparam int KW = ((FRAC_BITS + 2) > 16) ? (FRAC_BITS + 2) : 16;
  localparam int PW = UW + KW;
  localparam int SW = PW + 2;
  localparam int RW = SW + FRAC_BITS + 1;
  localparam int QW = 50;
  localparam int XW = 52;
  localparam logic signed [KW-1:0] ONE_K = KW'(64'd1 << FRAC_BITS);

  // Configuration registers
  logic [3:0]         mode;
  logic signed [15:0] scale [3];
  logic signed [15:0] offset [3];
  trig_status_t       trig;
  logic               trig_load;
  logic               accept;

  assign trig_load = cfg_en && (reg_idx_t'(cfg_index) == REG_ANGLE);
  assign busy      = trig.busy;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TRANSLATE;
      for (int i = 0; i < 3; i++) begin
        scale[i]  <= 16'sd512;
        offset[i] <= 16'sd10;
      end
    end else if (cfg_en) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:     mode      <= cfg_data[3:0];
        REG_SCALE_X:  scale[0]  <= cfg_data;
        REG_SCALE_Y:  scale[1]  <= cfg_data;
        REG_SCALE_Z:  scale[2]  <= cfg_data;
        REG_OFFSET_X: offset[0] <= cfg_data;
        REG_OFFSET_Y: offset[1] <= cfg_data;
        REG_OFFSET_Z: offset[2] <= cfg_data;
        default:      ;
      endcase
    end
  end

  vat_trig u_trig (
    .clk    (clk),
    .rst    (rst),
    .load   (trig_load),
    .angle  (cfg_data),
    .status (trig)
  );

  // Stage 1 operand select: r = u1*k1 + u2*k2 + add, rounded for rotations
  logic signed [UW-1:0] vin [3];
  logic signed [UW-1:0] offs [3];
  logic signed [KW-1:0] c_k, s_k;
  logic signed [UW-1:0] op_u1 [3];
  logic signed [UW-1:0] op_u2 [3];
  logic signed [KW-1:0] op_k1 [3];
  logic signed [KW-1:0] op_k2 [3];
  logic signed [SW-1:0] op_add [3];
  logic                 op_rot [3];

  always_comb begin
    vin[0] = UW'(vertex_x);
    vin[1] = UW'(vertex_y);
    vin[2] = UW'(vertex_z);
    c_k    = KW'(trig.cos_val);
    s_k    = KW'(trig.sin_val);
    for (int i = 0; i < 3; i++) begin
      offs[i]   = UW'(offset[i]);
      op_u1[i]  = vin[i];
      op_k1[i]  = ONE_K;
      op_u2[i]  = '0;
      op_k2[i]  = '0;
      op_add[i] = '0;
      op_rot[i] = 1'b0;
    end
    case (mode)
      MODE_TRANSLATE: begin
        for (int i = 0; i < 3; i++) begin
          op_u1[i] = vin[i] + offs[i];
        end
      end
      MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          op_k1[i] = KW'(scale[i]);
        end
      end
      MODE_SCALE_PT: begin
        for (int i = 0; i < 3; i++) begin
          op_u1[i]  = vin[i] - offs[i];
          op_k1[i]  = KW'(scale[i]);
          op_add[i] = SW'(offset[i]) <<< FRAC_BITS;
        end
      end
      MODE_ROT_X: begin
        op_u1[1] = vin[1]; op_k1[1] = c_k; op_u2[1] = -vin[2]; op_k2[1] = s_k;
        op_u1[2] = vin[1]; op_k1[2] = s_k; op_u2[2] = vin[2];  op_k2[2] = c_k;
        op_rot[1] = 1'b1;
        op_rot[2] = 1'b1;
      end
      MODE_ROT_Y: begin
        op_u1[0] = vin[0]; op_k1[0] = c_k; op_u2[0] = vin[2];  op_k2[0] = s_k;
        op_u1[2] = vin[2]; op_k1[2] = c_k; op_u2[2] = -vin[0]; op_k2[2] = s_k;
        op_rot[0] = 1'b1;
        op_rot[2] = 1'b1;
      end
      MODE_ROT_Z: begin
        op_u1[0] = vin[0]; op_k1[0] = c_k; op_u2[0] = -vin[1]; op_k2[0] = s_k;
        op_u1[1] = vin[0]; op_k1[1] = s_k; op_u2[1] = vin[1];  op_k2[1] = c_k;
        op_rot[0] = 1'b1;
        op_rot[1] = 1'b1;
      end
      MODE_REFL_XY: op_u1[2] = -vin[2];
      MODE_REFL_YZ: op_u1[0] = -vin[0];
      MODE_REFL_XZ: op_u1[1] = -vin[1];
      default: ;
    endcase
  end

  // Pipeline registers
  logic                 v1, v2, v3, v4, v5;
  logic signed [UW-1:0] s1_u1 [3];
  logic signed [UW-1:0] s1_u2 [3];
  logic signed [KW-1:0] s1_k1 [3];
  logic signed [KW-1:0] s1_k2 [3];
  logic signed [SW-1:0] s1_add [3];
  logic                 s1_rot [3];
  logic signed [PW-1:0] s2_p1 [3];
  logic signed [PW-1:0] s2_p2 [3];
  logic signed [SW-1:0] s2_add [3];
  logic                 s2_rot [3];
  logic signed [SW-1:0] s3_sum [3];
  logic                 s3_rot [3];
  logic signed [31:0]   s4_r [3];
  logic signed [31:0]   s5_r [3];
  logic signed [QW-1:0] s5_px_c, s5_px_s2, s5_px_cs, s5_py_c, s5_py_s;

  logic signed [RW-1:0] rnd [3];
  logic signed [XW-1:0] px_sum, py_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s3_rot[i]) begin
        rnd[i] = ((RW'(s3_sum[i]) <<< FRAC_BITS) + RW'(4096)) >>> 13;
      end else begin
        rnd[i] = RW'(s3_sum[i]);
      end
    end
    px_sum = XW'(s5_px_c) + XW'(s5_px_s2) + XW'(s5_px_cs) + XW'(32768);
    py_sum = XW'(s5_py_c) - XW'(s5_py_s) + XW'(32768);
  end

  // Advance valid bits every cycle; the result side never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // Datapath stages: operands, products, sum, round and saturate, projection, output
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_u1[i]  <= op_u1[i];
      s1_u2[i]  <= op_u2[i];
      s1_k1[i]  <= op_k1[i];
      s1_k2[i]  <= op_k2[i];
      s1_add[i] <= op_add[i];
      s1_rot[i] <= op_rot[i];
      s2_p1[i]  <= PW'(s1_u1[i]) * PW'(s1_k1[i]);
      s2_p2[i]  <= PW'(s1_u2[i]) * PW'(s1_k2[i]);
      s2_add[i] <= s1_add[i];
      s2_rot[i] <= s1_rot[i];
      s3_sum[i] <= SW'(s2_p1[i]) + SW'(s2_p2[i]) + s2_add[i];
      s3_rot[i] <= s2_rot[i];
      s4_r[i]   <= sat32(64'(rnd[i]));
      s5_r[i]   <= s4_r[i];
    end
    // Projection products
    s5_px_c  <= QW'(s4_r[0]) * QW'(PROJ_C);
    s5_px_s2 <= QW'(s4_r[1]) * QW'(PROJ_S2);
    s5_px_cs <= QW'(s4_r[2]) * QW'(PROJ_CS);
    s5_py_c  <= QW'(s4_r[1]) * QW'(PROJ_C);
    s5_py_s  <= QW'(s4_r[2]) * QW'(PROJ_S);
    // Output beat
    out_x  <= s5_r[0];
    out_y  <= s5_r[1];
    out_z  <= s5_r[2];
    proj_x <= sat32(64'(px_sum >>> 16));
    proj_y <= sat32(64'(py_sum >>> 16));
  end

  // Every accepted vertex yields a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted vertex produced no result");

  // No result without an earlier accepted vertex
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result without accepted vertex");

  // The trig unit only starts on an angle write
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cfg_en && (cfg_index == REG_ANGLE)))
    else $error("trig unit started without angle write");

endmodule

`default_nettype wire
